[rtl/core/hal_pkg.sv]
// Shared types, codes and mask helpers for the host allow-list matcher.
// No dependencies; every other file of the block but hal_ifs imports this package.
package hal_pkg;

  localparam int V4_ENTRIES_DEF = 16;
  localparam int V6_ENTRIES_DEF = 16;

  localparam logic [7:0] V4_HOST_LEN = 8'd32;
  localparam logic [7:0] V6_HOST_LEN = 8'd128;
  localparam logic [7:0] V6_HALF_LEN = 8'd64;

  typedef enum logic [1:0] {
    ACT_ADD_V4 = 2'd0,
    ACT_ADD_V6 = 2'd1,
    ACT_CHK_V4 = 2'd2,
    ACT_CHK_V6 = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PREFIX = 2'd1,
    ST_BAD_MASK   = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] mask;
    logic [15:0] port;
  } v4_rule_t;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix;
    logic [15:0] port;
  } v6_rule_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic do_add;
    logic scan_start;
    logic scan_step;
    logic set_check;
    logic check_allowed;
    logic load_out;
  } hal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_add;
    logic empty;
    logic hit;
    logic last;
  } hal_stat_t;

  // Top p bits set, p in 0..32.
  function automatic logic [31:0] v4_prefix_mask(input logic [5:0] p);
    return ~(32'hFFFF_FFFF >> p);
  endfunction

  // Nonzero and contiguous from the most significant bit.
  function automatic logic v4_mask_ok(input logic [31:0] m);
    logic [31:0] low;
    low = ~m + 32'd1;
    return (m != 32'd0) && ((low & (low - 32'd1)) == 32'd0);
  endfunction

  function automatic logic [63:0] v6_mask_hi(input logic [7:0] p);
    logic [63:0] m;
    if (p >= V6_HALF_LEN) begin
      m = '1;
    end else begin
      m = ~(64'hFFFF_FFFF_FFFF_FFFF >> p);
    end
    return m;
  endfunction

  function automatic logic [63:0] v6_mask_lo(input logic [7:0] p);
    logic [63:0] m;
    if (p <= V6_HALF_LEN) begin
      m = '0;
    end else begin
      m = ~(64'hFFFF_FFFF_FFFF_FFFF >> (p - V6_HALF_LEN));
    end
    return m;
  endfunction

endpackage

[rtl/core/hal_ifs.sv]
// Valid/ready channel interfaces for the request and result beats.
// No dependencies.
interface hal_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [7:0]  prefix_length;
  logic        mask_given;
  logic [31:0] mask_value;
  logic [15:0] port_number;

  modport source (
    output valid, action, address_high, address_low, prefix_length,
           mask_given, mask_value, port_number,
    input  ready
  );
  modport sink (
    input  valid, action, address_high, address_low, prefix_length,
           mask_given, mask_value, port_number,
    output ready
  );
endinterface

interface hal_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [1:0] status;

  modport source (output valid, allowed, status, input ready);
  modport sink (input valid, allowed, status, output ready);
endinterface

[rtl/core/hal_ctrl.sv]
// Controller state machine: sequences capture, add, table scan and result hand-off.
// Depends on hal_pkg.
module hal_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  hal_pkg::hal_stat_t stat,
  output hal_pkg::hal_cmd_t  cmd
);
  import hal_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_add) begin
          cmd.do_add = 1'b1;
          state_next = S_DONE;
        end else if (stat.empty) begin
          cmd.set_check = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          cmd.set_check     = 1'b1;
          cmd.check_allowed = 1'b1;
          state_next        = S_DONE;
        end else if (stat.last) begin
          cmd.set_check = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        // The result moves to the output register once it is free.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[rtl/core/hal_datapath.sv]
// Datapath: request register, rule tables in memories, add checks, scan compare
// and the output register. Depends on hal_pkg.
module hal_datapath #(
  parameter int V4_ENTRIES = hal_pkg::V4_ENTRIES_DEF,
  parameter int V6_ENTRIES = hal_pkg::V6_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         action,
  input  logic [63:0]        address_high,
  input  logic [63:0]        address_low,
  input  logic [7:0]         prefix_length,
  input  logic               mask_given,
  input  logic [31:0]        mask_value,
  input  logic [15:0]        port_number,
  input  hal_pkg::hal_cmd_t  cmd,
  output hal_pkg::hal_stat_t stat,
  output logic               allowed,
  output logic [1:0]         status
);
  import hal_pkg::*;

  localparam int A4 = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
  localparam int A6 = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
  localparam int C4 = $clog2(V4_ENTRIES + 1);
  localparam int C6 = $clog2(V6_ENTRIES + 1);
  localparam int IW = (C4 > C6) ? C4 : C6;

  // Captured request.
  action_t     act;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [7:0]  plen;
  logic        given;
  logic [31:0] mval;
  logic [15:0] port;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act     <= action_t'(action);
      addr_hi <= address_high;
      addr_lo <= address_low;
      plen    <= prefix_length;
      given   <= mask_given;
      mval    <= mask_value;
      port    <= port_number;
    end
  end

  logic [C4-1:0] v4_count;
  logic [C6-1:0] v6_count;
  logic          is_v6;
  logic          full4, full6;

  assign is_v6 = act[0];
  assign full4 = (v4_count == C4'(V4_ENTRIES));
  assign full6 = (v6_count == C6'(V6_ENTRIES));

  // Add decode. A mask or prefix error wins over a full table.
  logic [5:0]  p4;
  logic [31:0] mask4;
  logic [7:0]  p6;
  status_t     st4, st6, add_status;

  always_comb begin
    p4    = (plen == 8'd0) ? 6'd32 : plen[5:0];
    mask4 = given ? mval : v4_prefix_mask(p4);
    if (given && !v4_mask_ok(mval)) begin
      st4 = ST_BAD_MASK;
    end else if (!given && (plen > V4_HOST_LEN)) begin
      st4 = ST_BAD_PREFIX;
    end else if (full4) begin
      st4 = ST_FULL;
    end else begin
      st4 = ST_OK;
    end

    p6 = (plen == 8'd0) ? V6_HOST_LEN : plen;
    if (plen > V6_HOST_LEN) begin
      st6 = ST_BAD_PREFIX;
    end else if (full6) begin
      st6 = ST_FULL;
    end else begin
      st6 = ST_OK;
    end
    add_status = is_v6 ? st6 : st4;
  end

  logic wr4, wr6;
  assign wr4 = cmd.do_add && !is_v6 && (st4 == ST_OK);
  assign wr6 = cmd.do_add && is_v6 && (st6 == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_count <= '0;
      v6_count <= '0;
    end else begin
      if (wr4) begin
        v4_count <= v4_count + 1'b1;
      end
      if (wr6) begin
        v6_count <= v6_count + 1'b1;
      end
    end
  end

  // Scan index and read pipeline.
  logic [IW-1:0] idx;
  logic [IW-1:0] sel_count;
  logic          issue;
  logic          rd_vld;
  logic          rd_last;

  assign sel_count = is_v6 ? IW'(v6_count) : IW'(v4_count);
  assign issue     = cmd.scan_step && (idx < sel_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else if (cmd.scan_start) begin
      idx     <= '0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      rd_vld  <= issue;
      rd_last <= (idx == sel_count - 1'b1);
      if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Rule memories: one write port for adds, one registered read port for the scan.
  v4_rule_t mem4 [V4_ENTRIES];
  v6_rule_t mem6 [V6_ENTRIES];
  v4_rule_t rd4;
  v6_rule_t rd6;

  always_ff @(posedge clk) begin
    if (wr4) begin
      mem4[v4_count[A4-1:0]] <= '{addr: addr_lo[31:0], mask: mask4, port: port};
    end
    if (issue && !is_v6) begin
      rd4 <= mem4[idx[A4-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr6) begin
      mem6[v6_count[A6-1:0]] <= '{addr_hi: addr_hi, addr_lo: addr_lo, prefix: p6, port: port};
    end
    if (issue && is_v6) begin
      rd6 <= mem6[idx[A6-1:0]];
    end
  end

  // Compare of the entry read in the previous cycle.
  logic [63:0] mh, ml;
  logic        m4, m6;

  always_comb begin
    mh = v6_mask_hi(rd6.prefix);
    ml = v6_mask_lo(rd6.prefix);
    m4 = ((rd4.addr & rd4.mask) == (addr_lo[31:0] & rd4.mask))
         && ((rd4.port == 16'd0) || (rd4.port == port));
    m6 = ((rd6.addr_hi & mh) == (addr_hi & mh)) && ((rd6.addr_lo & ml) == (addr_lo & ml))
         && ((rd6.port == 16'd0) || (rd6.port == port));
  end

  assign stat.is_add = !act[1];
  assign stat.empty  = (sel_count == '0);
  assign stat.hit    = rd_vld && (is_v6 ? m6 : m4);
  assign stat.last   = rd_vld && rd_last;

  // Pending result and output register.
  logic    res_allowed;
  status_t res_status;

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      res_allowed <= 1'b0;
      res_status  <= add_status;
    end else if (cmd.set_check) begin
      res_allowed <= cmd.check_allowed;
      res_status  <= ST_OK;
    end
    if (cmd.load_out) begin
      allowed <= res_allowed;
      status  <= res_status;
    end
  end

endmodule

[rtl/core/host_allowlist_match.sv]
// Top level of the host allow-list matcher: controller, datapath, channel wiring.
// Depends on hal_pkg, hal_ifs, hal_ctrl and hal_datapath.
//
// One request beat in, one result beat out. An add (IPv4 or IPv6 rule) passes the
// capture, decide and done states on its way to the result register. A check walks
// the selected rule table one entry per cycle through the memory's registered read
// port, over the stored rules of that family (up to V4_ENTRIES or V6_ENTRIES), and
// stops early at the first matching entry. A check against an empty table skips
// the scan. A new request is taken while a finished result still waits in the
// output register.
module host_allowlist_match #(
  parameter int V4_ENTRIES = hal_pkg::V4_ENTRIES_DEF,
  parameter int V6_ENTRIES = hal_pkg::V6_ENTRIES_DEF
) (
  input logic  clk,
  input logic  rst,
  hal_req_if.sink   request,
  hal_rsp_if.source result
);
  import hal_pkg::*;

  hal_cmd_t  cmd;
  hal_stat_t dp_stat;
  logic      in_ready;
  logic      out_valid;

  hal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .stat      (dp_stat),
    .cmd       (cmd)
  );

  hal_datapath #(
    .V4_ENTRIES (V4_ENTRIES),
    .V6_ENTRIES (V6_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .action        (request.action),
    .address_high  (request.address_high),
    .address_low   (request.address_low),
    .prefix_length (request.prefix_length),
    .mask_given    (request.mask_given),
    .mask_value    (request.mask_value),
    .port_number   (request.port_number),
    .cmd           (cmd),
    .stat          (dp_stat),
    .allowed       (result.allowed),
    .status        (result.status)
  );

  assign request.ready = in_ready;
  assign result.valid  = out_valid;

`ifndef SYNTHESIS
  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request accepted while another was in flight");

  // An allowed result, which only a check gives, never carries an error status.
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.allowed && (result.status != ST_OK)))
    else $error("result mixes an allow with an add status");

  // A loaded result is always presented on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("loaded result not presented");
`endif

endmodule

[sim/hal_checker.sv]
`timescale 1ns / 1ps
// Checker for the host allow-list matcher: watches the request and result channels,
// predicts each result from its own copy of the rule tables and compares field by field.
// Depends on hal_pkg and the channel interfaces in hal_ifs.
module hal_checker #(
  parameter int V4_DEPTH = hal_pkg::V4_ENTRIES_DEF,
  parameter int V6_DEPTH = hal_pkg::V6_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  hal_req_if   request,
  hal_rsp_if   result,
  output int   mismatch_count,
  output int   pending_count
);
  import hal_pkg::*;

  typedef struct packed {
    logic    allowed;
    status_t status;
  } verdict_t;

  v4_rule_t v4_rules [V4_DEPTH];
  v6_rule_t v6_rules [V6_DEPTH];
  int       v4_used;
  int       v6_used;
  verdict_t pending_verdicts [$];

  // Updates the shadow tables for one request beat and returns the verdict it earns.
  function automatic verdict_t apply_request(input action_t act, input logic [63:0] hi,
                                             input logic [63:0] lo, input logic [7:0] plen,
                                             input logic given, input logic [31:0] mval,
                                             input logic [15:0] port);
    verdict_t     v;
    logic [7:0]   len;
    logic [31:0]  m4;
    logic [127:0] m6;
    v.allowed = 1'b0;
    v.status  = ST_OK;
    case (act)
      ACT_ADD_V4: begin
        // A usable dotted mask is nonzero and its complement is a run of low ones.
        if (given && (mval == 32'd0 || ((~mval) & (~mval + 32'd1)) != 32'd0)) begin
          v.status = ST_BAD_MASK;
        end else if (!given && plen > V4_HOST_LEN) begin
          v.status = ST_BAD_PREFIX;
        end else if (v4_used >= V4_DEPTH) begin
          v.status = ST_FULL;
        end else begin
          len = (plen == 8'd0) ? V4_HOST_LEN : plen;
          m4  = given ? mval : (32'hFFFF_FFFF << (V4_HOST_LEN - len));
          v4_rules[v4_used] = '{addr: lo[31:0], mask: m4, port: port};
          v4_used++;
        end
      end
      ACT_ADD_V6: begin
        len = (plen == 8'd0) ? V6_HOST_LEN : plen;
        if (len > V6_HOST_LEN) begin
          v.status = ST_BAD_PREFIX;
        end else if (v6_used >= V6_DEPTH) begin
          v.status = ST_FULL;
        end else begin
          v6_rules[v6_used] = '{addr_hi: hi, addr_lo: lo, prefix: len, port: port};
          v6_used++;
        end
      end
      ACT_CHK_V4: begin
        for (int i = 0; i < v4_used; i++) begin
          if ((((v4_rules[i].addr ^ lo[31:0]) & v4_rules[i].mask) == 32'd0) &&
              (v4_rules[i].port == 16'd0 || v4_rules[i].port == port)) begin
            v.allowed = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < v6_used; i++) begin
          m6 = {128{1'b1}} << (V6_HOST_LEN - v6_rules[i].prefix);
          if (((({v6_rules[i].addr_hi, v6_rules[i].addr_lo} ^ {hi, lo}) & m6) == 128'd0) &&
              (v6_rules[i].port == 16'd0 || v6_rules[i].port == port)) begin
            v.allowed = 1'b1;
          end
        end
      end
    endcase
    return v;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      v4_used = 0;
      v6_used = 0;
      pending_verdicts.delete();
    end else begin
      // The result side is handled first: a beat accepted on this edge can never
      // answer a request accepted on the same edge.
      if (result.valid && result.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result beat with no request waiting: allowed %0d status %0d",
                 result.allowed, result.status);
          mismatch_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (result.allowed !== want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, result.allowed);
            mismatch_count++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatch_count++;
          end
        end
      end
      if (request.valid && request.ready) begin
        pending_verdicts.push_back(apply_request(action_t'(request.action),
                                                 request.address_high, request.address_low,
                                                 request.prefix_length, request.mask_given,
                                                 request.mask_value, request.port_number));
      end
    end
    pending_count <= pending_verdicts.size();
  end

endmodule

[sim/host_allowlist_match_tb.sv]
`timescale 1ns / 1ps
// Top of the host allow-list matcher testbench: clock, reset, request and result drivers.
// Depends on hal_pkg, hal_ifs, host_allowlist_match and hal_checker.
module host_allowlist_match_tb;
  import hal_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_DEPTH   = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rsp_ready = 1'b0;
  int   cycle_count = 0;
  int   tx_idle_pct = 21;
  int   rx_idle_pct = 88;
  int   hold_left = 0;
  bit   long_hold_go = 1'b0;
  bit   long_hold_done = 1'b0;
  int   mismatch_count;
  int   pending_count;

  // Addresses and ports of earlier rule beats, so that checks hit stored rules.
  logic [31:0] v4_pool_addr [$];
  logic [15:0] v4_pool_port [$];
  logic [63:0] v6_pool_hi [$];
  logic [63:0] v6_pool_lo [$];
  logic [15:0] v6_pool_port [$];

  hal_req_if req_if ();
  hal_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_ready;

  host_allowlist_match i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (rsp_if)
  );

  hal_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .request        (req_if),
    .result         (rsp_if),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_go && !long_hold_done) begin
      rsp_ready      <= 1'b0;
      hold_left      <= HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one request beat and returns at the edge that accepts it; valid stays high.
  task automatic send_item(input action_t act, input logic [63:0] hi, input logic [63:0] lo,
                           input logic [7:0] plen, input logic given,
                           input logic [31:0] mval, input logic [15:0] port);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.address_high  <= hi;
    req_if.address_low   <= lo;
    req_if.prefix_length <= plen;
    req_if.mask_given    <= given;
    req_if.mask_value    <= mval;
    req_if.port_number   <= port;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (act == ACT_ADD_V4 && v4_pool_addr.size() < POOL_DEPTH) begin
      v4_pool_addr.push_back(lo[31:0]);
      v4_pool_port.push_back(port);
    end else if (act == ACT_ADD_V6 && v6_pool_hi.size() < POOL_DEPTH) begin
      v6_pool_hi.push_back(hi);
      v6_pool_lo.push_back(lo);
      v6_pool_port.push_back(port);
    end
  endtask

  // Mostly well-formed rules and checks aimed at stored rules, some pure noise.
  task automatic send_random_item();
    action_t     act;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  plen;
    logic        given;
    logic [31:0] mval;
    logic [15:0] port;
    int          pick;
    int          k;
    int          bit_pos;
    hi    = {$urandom, $urandom};
    lo    = {$urandom, $urandom};
    plen  = 8'($urandom_range(255));
    given = 1'($urandom_range(1));
    mval  = $urandom;
    port  = 16'($urandom);
    pick  = $urandom_range(99);
    if (pick < 5) begin
      act = action_t'($urandom_range(3));
    end else if (pick < 11) begin
      act = ACT_ADD_V4;
      if (given) begin
        k = $urandom_range(9);
        if (k == 0) begin
          mval = 32'd0;
        end else if (k > 2) begin
          mval = 32'hFFFF_FFFF << $urandom_range(31);
        end
      end else if ($urandom_range(9) != 0) begin
        plen = 8'($urandom_range(32));
      end
      if ($urandom_range(2) == 0) port = 16'd0;
    end else if (pick < 17) begin
      act = ACT_ADD_V6;
      if ($urandom_range(9) != 0) plen = 8'($urandom_range(128));
      if ($urandom_range(2) == 0) port = 16'd0;
    end else if (pick < 58) begin
      act = ACT_CHK_V4;
      if (v4_pool_addr.size() != 0 && $urandom_range(3) != 0) begin
        k = $urandom_range(v4_pool_addr.size() - 1);
        lo[31:0] = v4_pool_addr[k];
        if ($urandom_range(1)) begin
          bit_pos = $urandom_range(31);
          lo[bit_pos] = ~lo[bit_pos];
        end
        if ($urandom_range(2) != 0) port = v4_pool_port[k];
      end
    end else begin
      act = ACT_CHK_V6;
      if (v6_pool_hi.size() != 0 && $urandom_range(3) != 0) begin
        k  = $urandom_range(v6_pool_hi.size() - 1);
        hi = v6_pool_hi[k];
        lo = v6_pool_lo[k];
        if ($urandom_range(1)) begin
          bit_pos = $urandom_range(127);
          if (bit_pos < 64) lo[bit_pos] = ~lo[bit_pos];
          else hi[bit_pos - 64] = ~hi[bit_pos - 64];
        end
        if ($urandom_range(2) != 0) port = v6_pool_port[k];
      end
    end
    send_item(act, hi, lo, plen, given, mval, port);
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ADD_V4;
    req_if.address_high  = '0;
    req_if.address_low   = '0;
    req_if.prefix_length = '0;
    req_if.mask_given    = 1'b0;
    req_if.mask_value    = '0;
    req_if.port_number   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty tables, mask and prefix errors, length extremes, port rules.
    send_item(ACT_CHK_V4, '0, '0, 8'd0, 1'b0, '0, 16'd0);
    send_item(ACT_CHK_V6, '1, '1, 8'd255, 1'b1, '1, 16'hFFFF);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_C0A8_0001, 8'd8, 1'b1, 32'd0, 16'd0);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_C0A8_0001, 8'd8, 1'b1, 32'hFF00_FF00, 16'd0);
    send_item(ACT_ADD_V4, '1, 64'hFFFF_FFFF_C0A8_0001, 8'd0, 1'b1, 32'h8000_0000, 16'd0);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_0A00_0001, 8'd255, 1'b1, 32'hFFFF_FFFF,
              16'hFFFF);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_0A00_0002, 8'd33, 1'b0, 32'hFFFF_FFFF, 16'd0);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_0A00_0002, 8'd255, 1'b0, '0, 16'd0);
    send_item(ACT_ADD_V4, '1, 64'h1234_5678_FFFF_FFFF, 8'd0, 1'b0, 32'h0F0F_0F0F, 16'd80);
    send_item(ACT_ADD_V4, '0, 64'h0000_0000_0A0B_0C00, 8'd24, 1'b0, '0, 16'd443);
    send_item(ACT_ADD_V6, '0, '0, 8'd129, 1'b0, '0, 16'd0);
    send_item(ACT_ADD_V6, '0, '0, 8'd255, 1'b1, '1, 16'd0);
    send_item(ACT_ADD_V6, '1, '1, 8'd0, 1'b1, 32'd0, 16'hFFFF);
    send_item(ACT_ADD_V6, 64'h2001_0DB8_0000_0001, 64'h0000_0000_0000_0001, 8'd64, 1'b0,
              '0, 16'd0);
    send_item(ACT_ADD_V6, 64'hFE80_0000_0000_0000, 64'h8000_0000_0000_0000, 8'd65, 1'b0,
              '0, 16'd53);
    send_item(ACT_ADD_V6, '0, 64'h5555_5555_5555_5555, 8'd1, 1'b0, '0, 16'd22);
    send_item(ACT_CHK_V4, '0, 64'h0000_0000_C000_0001, 8'd0, 1'b0, '0, 16'd1234);
    send_item(ACT_CHK_V4, '0, 64'h0000_0000_0A00_0001, 8'd0, 1'b0, '0, 16'hFFFF);
    send_item(ACT_CHK_V4, '0, 64'h0000_0000_0A00_0001, 8'd0, 1'b0, '0, 16'hFFFE);
    send_item(ACT_CHK_V4, '1, 64'hFFFF_FFFF_0A0B_0CFF, 8'd0, 1'b0, '0, 16'd443);
    send_item(ACT_CHK_V4, '0, 64'h0000_0000_0A0B_0CFF, 8'd0, 1'b0, '0, 16'd444);
    send_item(ACT_CHK_V6, '1, '1, 8'd0, 1'b0, '0, 16'hFFFF);
    send_item(ACT_CHK_V6, 64'h2001_0DB8_0000_0001, 64'hDEAD_BEEF_0000_0000, 8'd0, 1'b0,
              '0, 16'd7);
    send_item(ACT_CHK_V6, 64'h7FFF_FFFF_FFFF_FFFF, '0, 8'd0, 1'b0, '0, 16'd22);
    send_item(ACT_CHK_V6, 64'hFE80_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 1'b0,
              '0, 16'd53);

    // Random part in three idling phases; the long hold-off opens the last one.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 88;
        rx_idle_pct <= 21;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        long_hold_go <= 1'b1;
      end
      send_random_item();
    end
    req_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/hal_pkg.sv
rtl/core/hal_ifs.sv
rtl/core/hal_ctrl.sv
rtl/core/hal_datapath.sv
rtl/core/host_allowlist_match.sv
sim/hal_checker.sv
sim/host_allowlist_match_tb.sv
